// File: rtl/mqsc_pkg.sv
// ----------------------------------------------------------------------------
// mqsc_pkg
// Shared types, codes and the quadrature step table of the scaled counter.
// ----------------------------------------------------------------------------
package mqsc_pkg;

  localparam int PIN_W   = 24;
  localparam int ADDR_W  = 3;
  localparam int ACC_W   = 16;
  localparam int SCALE_W = 15;
  localparam int DELTA_W = 8;

  localparam logic REG_ACTIVE_MICE     = 1'b0;
  localparam logic REG_COUNTS_PER_STEP = 1'b1;

  localparam logic [2:0]         ACTIVE_MICE_RESET = 3'd6;
  localparam logic [SCALE_W-1:0] COUNTS_RESET      = 15'd1;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TAKE   = 2'd1,
    ACT_INIT   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EXE,
    ST_DIV,
    ST_TKZ
  } state_t;

  typedef struct packed {
    logic [1:0]                phase;
    logic [ACC_W-1:0]          acc;
    logic signed [DELTA_W-1:0] pend;
  } entry_t;

  function automatic logic signed [1:0] step_of(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:   s = 2'sb01;
      4'd2, 4'd4, 4'd11, 4'd13:  s = 2'sb11;
      default:                   s = 2'sb00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/mqsc_if.sv
// ----------------------------------------------------------------------------
// mqsc_in_if / mqsc_out_if
// Valid/ready channels for pin sample items and delta results.
// ----------------------------------------------------------------------------
interface mqsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [23:0] pin_levels;
  logic [2:0]  mouse_select;

  modport source (output valid, action, pin_levels, mouse_select, input ready);
  modport sink (input valid, action, pin_levels, mouse_select, output ready);
endinterface

interface mqsc_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;

  modport source (output valid, delta_x, delta_y, input ready);
  modport sink (input valid, delta_x, delta_y, output ready);
endinterface

// File: rtl/mqsc_div.sv
// ----------------------------------------------------------------------------
// mqsc_div
// Radix-2 restoring divider, 16-bit magnitude by 15-bit scale.
// ----------------------------------------------------------------------------
module mqsc_div
  import mqsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ACC_W-1:0]   dividend,
  input  logic [SCALE_W-1:0] divisor,
  output logic               busy,
  output logic [ACC_W-1:0]   quot,
  output logic [SCALE_W-1:0] rem
);

  logic [ACC_W-1:0]   dq;
  logic [SCALE_W-1:0] rm;
  logic [3:0]         cnt;
  logic [ACC_W-1:0]   trial;
  logic               ge;

  assign trial = {rm, dq[ACC_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq <= dividend;
      rm <= '0;
    end else if (busy) begin
      dq <= {dq[ACC_W-2:0], ge};
      rm <= ge ? SCALE_W'(trial - {1'b0, divisor}) : trial[SCALE_W-1:0];
    end
  end

  assign quot = dq;
  assign rem  = rm;

endmodule

// File: rtl/multi_quadrature_scaled_counter.sv
// ----------------------------------------------------------------------------
// multi_quadrature_scaled_counter
// Multi-mouse quadrature decoder with scaled, saturating delta counters.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one beat per command: sample pins, take one
// mouse's deltas, or init. Output channel out_ch returns one beat per take.
// Channel state (phase, accumulator, pending delta) lives in one RAM with a
// registered read; each channel is read, updated and written back by a
// single sequencer. Every command spends its accept cycle in idle.
// A sample then walks 2*active channels; any channel whose count reaches
// the scale also waits on the shared restoring divider, which does one
// quotient bit per cycle. Init walks all channels; a take reads the
// mouse's two channels in turn, or loads a zero result when the mouse
// lies beyond MOUSE_COUNT. The next command is accepted once the walk
// ends, even while a result still waits in the output register; a take
// then holds until that register frees up. Reset (rst, synchronous)
// clears per-entry valid bits so the RAM reads as zero, and restores the
// config registers; no clearing pass is needed. Config registers sit on
// an APB port: active_mice at 0x0, counts_per_step at 0x4, both to be
// written by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module multi_quadrature_scaled_counter
  import mqsc_pkg::*;
#(
  parameter int MOUSE_COUNT = 6
) (
  input  logic              clk,
  input  logic              rst,
  mqsc_in_if.sink           in_ch,
  mqsc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CH    = 2 * MOUSE_COUNT;
  localparam int CH_W  = $clog2(CH);
  localparam int EXT_W = (4 * MOUSE_COUNT > PIN_W) ? 4 * MOUSE_COUNT : PIN_W;

  // config
  logic [2:0]         active_mice;
  logic [SCALE_W-1:0] counts_per_step;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mice     <= ACTIVE_MICE_RESET;
      counts_per_step <= COUNTS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ACTIVE_MICE:     active_mice     <= pwdata[2:0];
        REG_COUNTS_PER_STEP: counts_per_step <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACTIVE_MICE:     prdata = 32'(active_mice);
      REG_COUNTS_PER_STEP: prdata = 32'(counts_per_step);
      default:             prdata = '0;
    endcase
  end

  logic [2:0] n_act;
  assign n_act = (32'(active_mice) > MOUSE_COUNT) ? 3'(MOUSE_COUNT) : active_mice;

  // sequencer registers
  state_t                    state, state_next;
  logic [CH_W-1:0]           ch, ch_next;
  action_t                   act;
  logic [PIN_W-1:0]          pins;
  logic [2:0]                sel;
  logic signed [DELTA_W-1:0] dx_hold, dx_hold_next;

  // channel RAM
  entry_t          mem [CH];
  logic [CH-1:0]   vld;
  entry_t          rd_q;
  logic            rd_vld;
  logic            rd_en, wr_en;
  entry_t          wr_data;
  entry_t          ent;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= mem[ch];
      rd_vld <= vld[ch];
    end
    if (wr_en) begin
      mem[ch] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[ch] <= 1'b1;
    end
  end

  assign ent = rd_vld ? rd_q : '0;

  // per-channel datapath
  logic [EXT_W-1:0]          pins_ext;
  logic [CH_W-2:0]           m_idx;
  logic [3:0]                nib;
  logic [1:0]                cur;
  logic signed [1:0]         step;
  logic [ACC_W-1:0]          acc_sum;
  logic signed [ACC_W:0]     a17, s17;
  logic                      hit;
  logic                      m_active;
  logic [ACC_W-1:0]          mag;

  assign pins_ext = EXT_W'(pins);
  assign m_idx    = ch[CH_W-1:1];
  assign nib      = pins_ext[{m_idx, 2'b00} +: 4];
  assign cur      = ch[0] ? nib[3:2] : nib[1:0];
  assign step     = step_of({ent.phase, cur});
  assign acc_sum  = ent.acc + {{(ACC_W-2){step[1]}}, step};
  assign a17      = {acc_sum[ACC_W-1], acc_sum};
  assign s17      = {2'b00, counts_per_step};
  assign hit      = (counts_per_step != '0) && ((a17 >= s17) || (a17 <= -s17));
  assign m_active = 32'(m_idx) < 32'(n_act);
  assign mag      = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : acc_sum;

  // divider and post-divide update
  logic               div_start, div_busy;
  logic [ACC_W-1:0]   quot;
  logic [SCALE_W-1:0] rem;

  mqsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (counts_per_step),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  logic                      neg;
  logic signed [DELTA_W-1:0] q8, pend_sat;
  logic signed [DELTA_W:0]   pend_sum;
  logic [ACC_W-1:0]          r16;

  assign neg = acc_sum[ACC_W-1];

  always_comb begin
    if (neg) begin
      q8 = (quot > 16'd128) ? -8'sd128 : DELTA_W'(-quot);
    end else begin
      q8 = (quot > 16'd127) ? 8'sd127 : quot[DELTA_W-1:0];
    end
    pend_sum = {ent.pend[DELTA_W-1], ent.pend} + {q8[DELTA_W-1], q8};
    if (pend_sum[DELTA_W] != pend_sum[DELTA_W-1]) begin
      pend_sat = pend_sum[DELTA_W] ? -8'sd128 : 8'sd127;
    end else begin
      pend_sat = pend_sum[DELTA_W-1:0];
    end
    r16 = neg ? ACC_W'(-{1'b0, rem}) : ACC_W'(rem);
  end

  // output register
  logic                      out_free, out_load;
  logic signed [DELTA_W-1:0] out_dx, out_dy;

  assign out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.delta_x <= out_dx;
      out_ch.delta_y <= out_dy;
    end
  end

  // state machine
  logic sample_last, init_last;

  assign sample_last = 32'(ch) == 2 * 32'(n_act) - 1;
  assign init_last   = 32'(ch) == CH - 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    ch      <= ch_next;
    dx_hold <= dx_hold_next;
    if (in_ch.valid && in_ch.ready) begin
      act  <= action_t'(in_ch.action);
      pins <= in_ch.pin_levels;
      sel  <= in_ch.mouse_select;
    end
  end

  always_comb begin
    state_next   = state;
    ch_next      = ch;
    dx_hold_next = dx_hold;
    in_ch.ready  = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_data      = ent;
    div_start    = 1'b0;
    out_load     = 1'b0;
    out_dx       = '0;
    out_dy       = '0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (action_t'(in_ch.action))
            ACT_SAMPLE: begin
              ch_next = '0;
              if (n_act != '0) begin
                state_next = ST_RD;
              end
            end
            ACT_TAKE: begin
              if (32'(in_ch.mouse_select) < MOUSE_COUNT) begin
                ch_next    = CH_W'({in_ch.mouse_select, 1'b0});
                state_next = ST_RD;
              end else begin
                state_next = ST_TKZ;
              end
            end
            ACT_INIT: begin
              ch_next    = '0;
              state_next = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rd_en      = 1'b1;
        state_next = ST_EXE;
      end
      ST_EXE: begin
        case (act)
          ACT_SAMPLE: begin
            if (hit) begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end else begin
              wr_en         = 1'b1;
              wr_data.phase = cur;
              wr_data.acc   = acc_sum;
              if (sample_last) begin
                state_next = ST_IDLE;
              end else begin
                ch_next    = CH_W'(ch + 1'b1);
                state_next = ST_RD;
              end
            end
          end
          ACT_INIT: begin
            wr_en        = 1'b1;
            wr_data.pend = '0;
            if (m_active) begin
              wr_data.phase = cur;
              wr_data.acc   = '0;
            end
            if (init_last) begin
              state_next = ST_IDLE;
            end else begin
              ch_next    = CH_W'(ch + 1'b1);
              state_next = ST_RD;
            end
          end
          default: begin
            wr_data.pend = '0;
            if (!ch[0]) begin
              wr_en        = 1'b1;
              dx_hold_next = m_active ? ent.pend : '0;
              ch_next      = CH_W'(ch + 1'b1);
              state_next   = ST_RD;
            end else if (out_free) begin
              wr_en      = 1'b1;
              out_load   = 1'b1;
              out_dx     = dx_hold;
              out_dy     = m_active ? ent.pend : '0;
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_DIV: begin
        if (!div_busy) begin
          wr_en         = 1'b1;
          wr_data.phase = cur;
          wr_data.acc   = r16;
          wr_data.pend  = pend_sat;
          if (sample_last) begin
            state_next = ST_IDLE;
          end else begin
            ch_next    = CH_W'(ch + 1'b1);
            state_next = ST_RD;
          end
        end
      end
      ST_TKZ: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
